// File: rtl/pcmfc_pkg.sv
// shared constants and types for the pcm sample format converter
// no dependencies; used by the interfaces and the core

package pcmfc_pkg;

    // payload widths
    localparam int SAMPLE_W    = 32;
    localparam int CHANNEL_W   = 6;
    localparam int OUT_W       = 64;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;

    // channels at or above this index give a silent word
    localparam int MAX_CHANNEL = 64;

    // register indexes on the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SOURCE_BITS        = 3'd0,
        CFG_LEFT_GAIN          = 3'd1,
        CFG_RIGHT_GAIN         = 3'd2,
        CFG_OUT_VALID_BITS     = 3'd3,
        CFG_OUT_CONTAINER_BITS = 3'd4,
        CFG_OUT_BIG_ENDIAN     = 3'd5,
        CFG_OUT_FLOAT          = 3'd6
    } cfg_index_t;

    // recognized source widths
    localparam logic [5:0] SRC_BITS_24 = 6'd24;
    localparam logic [5:0] SRC_BITS_32 = 6'd32;

    // reset values
    localparam logic [5:0]  RST_SOURCE_BITS        = 6'd16;
    localparam logic [16:0] RST_GAIN               = 17'd65536;
    localparam logic [5:0]  RST_OUT_VALID_BITS     = 6'd24;
    localparam logic [6:0]  RST_OUT_CONTAINER_BITS = 7'd32;

    // float32 container and number of pipeline stages
    localparam logic [6:0] CONTAINER_F32 = 7'd32;
    localparam int         NUM_STAGES    = 7;

endpackage

// File: rtl/pcmfc_if.sv
// valid/ready stream interfaces for the converter: input samples and output words
// depends on pcmfc_pkg for payload widths

interface pcmfc_in_if;
    logic                                valid;
    logic                                ready;
    logic [pcmfc_pkg::SAMPLE_W-1:0]      sample_word;
    logic [pcmfc_pkg::CHANNEL_W-1:0]     channel;
    logic                                silent;

    modport source (output valid, output sample_word, output channel, output silent,
                    input ready);
    modport sink   (input valid, input sample_word, input channel, input silent,
                    output ready);
endinterface

interface pcmfc_out_if;
    logic                                valid;
    logic                                ready;
    logic [pcmfc_pkg::OUT_W-1:0]         out_bytes;

    modport source (output valid, output out_bytes, input ready);
    modport sink   (input valid, input out_bytes, output ready);
endinterface

// File: rtl/pcm_sample_format_converter_core.sv
// pcm sample format converter: gain, integer or float conversion, byte packing
// depends on pcmfc_pkg and the stream interfaces in pcmfc_if.sv
//
//  port    dir   handshake      payload
//  pcm     in    valid/ready    sample_word[31:0], channel[5:0], silent
//  drv     out   valid/ready    out_bytes[63:0]
//  cfg_*   in    cfg_we only    cfg_index[2:0], cfg_data[16:0]
//
// one word per cycle sustained while drv.ready is high, through seven register stages
// (decode, gain multiply, gain scale, gain round, normalize, round, pack); a word
// accepted at the input passes through them in that order before drv.valid shows it
// reset empties the pipeline and loads the default register values
// each stage holds while the next one is full and stalled; empty stages fill

module pcm_sample_format_converter_core #(
    parameter int MAX_CHANNEL = pcmfc_pkg::MAX_CHANNEL
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pcmfc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pcmfc_pkg::CFG_DATA_W-1:0]    cfg_data,
    pcmfc_in_if.sink                            pcm,
    pcmfc_out_if.source                         drv
);

    localparam int NS = pcmfc_pkg::NUM_STAGES;

    // configuration registers
    logic [5:0]  source_bits_reg;
    logic [16:0] left_gain_reg;
    logic [16:0] right_gain_reg;
    logic [5:0]  out_valid_bits_reg;
    logic [6:0]  out_container_bits_reg;
    logic        out_big_endian_reg;
    logic        out_float_reg;

    // pipeline control
    logic [NS:1]   vld_reg;
    logic [NS+1:1] rdy;

    // stage payloads
    logic [31:0] m1_reg;
    logic        neg1_reg, gen1_reg, zero1_reg;
    logic [15:0] g1_reg;

    logic [47:0] a2_reg;
    logic [31:0] m2_reg;
    logic        neg2_reg, gen2_reg, zero2_reg;

    logic [79:0] prod3_reg;
    logic [31:0] m3_reg;
    logic        neg3_reg, gen3_reg, zero3_reg;

    logic [31:0] m4_reg;
    logic        neg4_reg, zero4_reg;

    logic [63:0] iprod5_reg;
    logic [31:0] m5_reg;
    logic [4:0]  p5_reg;
    logic        neg5_reg, zero5_reg;

    logic [31:0] q6_reg;
    logic [23:0] frac6_reg;
    logic        rup6_reg;
    logic [4:0]  p6_reg;
    logic [63:0] f64_6_reg;
    logic        neg6_reg, nz6_reg, zero6_reg;

    logic [63:0] word7_reg;

    // derived configuration; the user must keep it stable while items are in flight, the block does not enforce it
    logic [4:0] sm1;
    logic [5:0] vclamp;
    logic [4:0] vm1;

    always_comb
    begin
        case (source_bits_reg)
            pcmfc_pkg::SRC_BITS_24: sm1 = 5'd23;
            pcmfc_pkg::SRC_BITS_32: sm1 = 5'd31;
            default:                sm1 = 5'd15;
        endcase
        if (out_valid_bits_reg < 6'd8)
            vclamp = 6'd8;
        else if (out_valid_bits_reg > 6'd32)
            vclamp = 6'd32;
        else
            vclamp = out_valid_bits_reg;
        vm1 = 5'(vclamp - 6'd1);
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_bits_reg        <= pcmfc_pkg::RST_SOURCE_BITS;
            left_gain_reg          <= pcmfc_pkg::RST_GAIN;
            right_gain_reg         <= pcmfc_pkg::RST_GAIN;
            out_valid_bits_reg     <= pcmfc_pkg::RST_OUT_VALID_BITS;
            out_container_bits_reg <= pcmfc_pkg::RST_OUT_CONTAINER_BITS;
            out_big_endian_reg     <= 1'b0;
            out_float_reg          <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pcmfc_pkg::CFG_SOURCE_BITS:        source_bits_reg <= cfg_data[5:0];
                pcmfc_pkg::CFG_LEFT_GAIN:          left_gain_reg <= cfg_data;
                pcmfc_pkg::CFG_RIGHT_GAIN:         right_gain_reg <= cfg_data;
                pcmfc_pkg::CFG_OUT_VALID_BITS:     out_valid_bits_reg <= cfg_data[5:0];
                pcmfc_pkg::CFG_OUT_CONTAINER_BITS: out_container_bits_reg <= cfg_data[6:0];
                pcmfc_pkg::CFG_OUT_BIG_ENDIAN:     out_big_endian_reg <= cfg_data[0];
                pcmfc_pkg::CFG_OUT_FLOAT:          out_float_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // a stage loads when it is empty or its word moves on
    always_comb
    begin
        rdy[NS+1] = drv.ready;
        for (int k = NS; k >= 1; k--)
            rdy[k] = !vld_reg[k] || rdy[k+1];
    end

    assign pcm.ready     = rdy[1];
    assign drv.valid     = vld_reg[NS];
    assign drv.out_bytes = word7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (rdy[1])
                vld_reg[1] <= pcm.valid;
            for (int k = 2; k <= NS; k++)
                if (rdy[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    // stage 1: sign extend, magnitude, gain select
    logic [32:0] ext1;
    logic [32:0] mag1;
    logic [16:0] gsel1;
    logic [31:0] m1_next;
    logic        neg1_next, gen1_next, zero1_next;
    logic [15:0] g1_next;

    always_comb
    begin
        case (source_bits_reg)
            pcmfc_pkg::SRC_BITS_24: ext1 = {{9{pcm.sample_word[23]}}, pcm.sample_word[23:0]};
            pcmfc_pkg::SRC_BITS_32: ext1 = {pcm.sample_word[31], pcm.sample_word};
            default:                ext1 = {{17{pcm.sample_word[15]}}, pcm.sample_word[15:0]};
        endcase
        neg1_next  = ext1[32];
        mag1       = neg1_next ? (33'd0 - ext1) : ext1;
        m1_next    = mag1[31:0];
        gsel1      = (pcm.channel == 6'd0) ? left_gain_reg : right_gain_reg;
        // gain applies only below unity, on the two gain channels
        gen1_next  = (pcm.channel < 6'd2) && !gsel1[16];
        g1_next    = gsel1[15:0];
        zero1_next = pcm.silent || ({1'b0, pcm.channel} >= 7'(MAX_CHANNEL));
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            m1_reg    <= m1_next;
            neg1_reg  <= neg1_next;
            gen1_reg  <= gen1_next;
            g1_reg    <= g1_next;
            zero1_reg <= zero1_next;
        end
    end

    // stage 2: magnitude times gain
    logic [47:0] a2_next;
    assign a2_next = 48'(m1_reg) * 48'(g1_reg);

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            a2_reg    <= a2_next;
            m2_reg    <= m1_reg;
            neg2_reg  <= neg1_reg;
            gen2_reg  <= gen1_reg;
            zero2_reg <= zero1_reg;
        end
    end

    // stage 3: times (2^(s-1) - 1) as shift and subtract
    logic [79:0] prod3_next;
    assign prod3_next = ({32'd0, a2_reg} << sm1) - {32'd0, a2_reg};

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            prod3_reg <= prod3_next;
            m3_reg    <= m2_reg;
            neg3_reg  <= neg2_reg;
            gen3_reg  <= gen2_reg;
            zero3_reg <= zero2_reg;
        end
    end

    // stage 4: round half away and drop s+15 bits
    logic [5:0]  kk4;
    logic [79:0] rnd4;
    logic [79:0] shr4;
    logic [31:0] m4_next;

    always_comb
    begin
        kk4     = {1'b0, sm1} + 6'd16;
        rnd4    = prod3_reg + (80'd1 << (kk4 - 6'd1));
        shr4    = rnd4 >> kk4;
        m4_next = gen3_reg ? shr4[31:0] : m3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            m4_reg    <= m4_next;
            neg4_reg  <= neg3_reg && (m4_next != 32'd0);
            zero4_reg <= zero3_reg;
        end
    end

    // stage 5: leading one position and integer scale product
    logic [4:0]  p5_next;
    logic [63:0] iprod5_next;

    always_comb
    begin
        p5_next = 5'd0;
        for (int i = 0; i < 32; i++)
            if (m4_reg[i])
                p5_next = 5'(i);
        iprod5_next = ({32'd0, m4_reg} << vm1) - {32'd0, m4_reg};
    end

    always_ff @(posedge clk)
    begin
        if (rdy[5])
        begin
            iprod5_reg <= iprod5_next;
            m5_reg     <= m4_reg;
            p5_reg     <= p5_next;
            neg5_reg   <= neg4_reg;
            zero5_reg  <= zero4_reg;
        end
    end

    // stage 6: integer rounding and saturation, float mantissa alignment
    logic [63:0] irnd6;
    logic [63:0] qw6;
    logic [63:0] vmax6;
    logic [31:0] fsh6;
    logic [4:0]  r6;
    logic [31:0] rem6;
    logic [31:0] half6;
    logic [23:0] frac6_next;
    logic        rup6_next;
    logic [63:0] f64sh6;
    logic [10:0] e11_6;
    logic [63:0] f64_6_next;
    logic        nz6_next;

    always_comb
    begin
        irnd6 = iprod5_reg + (64'd1 << (sm1 - 5'd1));
        qw6   = irnd6 >> sm1;
        vmax6 = (64'd1 << vm1) - 64'd1;
        if (!neg5_reg && qw6 > vmax6)
            qw6 = vmax6;
        if (neg5_reg && qw6 > vmax6 + 64'd1)
            qw6 = vmax6 + 64'd1;

        r6    = 5'd0;
        rem6  = 32'd0;
        half6 = 32'd0;
        rup6_next = 1'b0;
        if (p5_reg <= 5'd23)
        begin
            fsh6 = m5_reg << (5'd23 - p5_reg);
        end
        else
        begin
            r6    = p5_reg - 5'd23;
            fsh6  = m5_reg >> r6;
            rem6  = m5_reg & ((32'd1 << r6) - 32'd1);
            half6 = 32'd1 << (r6 - 5'd1);
            // round to nearest, ties to even
            rup6_next = (rem6 > half6) || ((rem6 == half6) && fsh6[0]);
        end
        frac6_next = fsh6[23:0];

        nz6_next   = m5_reg != 32'd0;
        f64sh6     = {32'd0, m5_reg} << (6'd52 - {1'b0, p5_reg});
        e11_6      = 11'd1023 + {6'd0, p5_reg} - {6'd0, sm1};
        f64_6_next = nz6_next ? {neg5_reg, e11_6, f64sh6[51:0]} : 64'd0;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[6])
        begin
            q6_reg    <= qw6[31:0];
            frac6_reg <= frac6_next;
            rup6_reg  <= rup6_next;
            p6_reg    <= p5_reg;
            f64_6_reg <= f64_6_next;
            neg6_reg  <= neg5_reg;
            nz6_reg   <= nz6_next;
            zero6_reg <= zero5_reg;
        end
    end

    // stage 7: finish float32, pick format, mask and order the bytes
    logic [24:0] f25_7;
    logic [22:0] fr23_7;
    logic [5:0]  pp7;
    logic [8:0]  exp9_7;
    logic [63:0] f32w7;
    logic [63:0] intw7;
    logic [63:0] sel7;
    logic [3:0]  n7;
    logic [63:0] mask7;
    logic [63:0] msk7;
    logic [63:0] rev7;
    logic [63:0] word7_next;

    always_comb
    begin
        f25_7 = {1'b0, frac6_reg} + {24'd0, rup6_reg};
        if (f25_7[24])
        begin
            fr23_7 = f25_7[23:1];
            pp7    = {1'b0, p6_reg} + 6'd1;
        end
        else
        begin
            fr23_7 = f25_7[22:0];
            pp7    = {1'b0, p6_reg};
        end
        exp9_7 = 9'd127 + {3'd0, pp7} - {4'd0, sm1};
        f32w7  = nz6_reg ? {32'd0, neg6_reg, exp9_7[7:0], fr23_7} : 64'd0;
        intw7  = neg6_reg ? (64'd0 - {32'd0, q6_reg}) : {32'd0, q6_reg};

        if (out_float_reg)
        begin
            if (out_container_bits_reg == pcmfc_pkg::CONTAINER_F32)
            begin
                sel7 = f32w7;
                n7   = 4'd4;
            end
            else
            begin
                sel7 = f64_6_reg;
                n7   = 4'd8;
            end
        end
        else
        begin
            sel7 = intw7;
            n7   = (out_container_bits_reg[6:3] > 4'd8) ? 4'd8 : out_container_bits_reg[6:3];
        end

        mask7 = (n7 >= 4'd8) ? {64{1'b1}} : ((64'd1 << {n7, 3'b000}) - 64'd1);
        msk7  = sel7 & mask7;
        // full byte swap, then slide the n written bytes down to byte 0
        for (int b = 0; b < 8; b++)
            rev7[8*b +: 8] = msk7[8*(7-b) +: 8];
        rev7 = rev7 >> {4'd8 - n7, 3'b000};

        if (zero6_reg)
            word7_next = 64'd0;
        else if (out_big_endian_reg)
            word7_next = rev7;
        else
            word7_next = msk7;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[7])
            word7_reg <= word7_next;
    end

endmodule
